### rtl/core/projective_pixel_coordinate_map_top_assert.svh
// assertion macros for the projective pixel coordinate map
// expects signals clk and rst_n in the module that uses them
`ifndef PROJECTIVE_PIXEL_COORDINATE_MAP_TOP_ASSERT_SVH
`define PROJECTIVE_PIXEL_COORDINATE_MAP_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PPCM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("ppcm same-cycle check failed");
// next-cycle implication
`define PPCM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("ppcm next-cycle check failed");
`else
`define PPCM_ASSERT_IMP(name, ante, cons)
`define PPCM_ASSERT_NXT(name, ante, cons)
`endif
`endif

### rtl/core/ppcm_pkg.sv
// shared constants, register codes and types for the projective pixel map
// no dependencies
package ppcm_pkg;

  localparam int COEF_W     = 48;
  localparam int FRAC_W     = 24;
  localparam int PIX_W      = 10;
  localparam int OUT_W      = 10;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_BYTE_SHIFT = 3;

  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;

  localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(1) << FRAC_W;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_X_COL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_ROW = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_OFS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_COL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_Y_ROW = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Y_OFS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_W_COL = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_W_ROW = 3'd7;

  // sideband that travels with an item through the divider
  typedef struct packed {
    logic valid;
    logic zero_w;
    logic neg_x;
    logic neg_y;
  } ppcm_ctl_t;

  function automatic logic [COEF_W-1:0] coef_reset(input logic [REG_IDX_W-1:0] idx);
    logic [COEF_W-1:0] v;
    v = '0;
    if (idx == REG_X_COL || idx == REG_Y_ROW) begin
      v = Q_ONE;
    end
    return v;
  endfunction

endpackage

### rtl/core/ppcm_div.sv
// pipelined restoring divider, two numerators over one shared denominator
// uses ppcm_pkg for the sideband struct
module ppcm_div import ppcm_pkg::*; #(
  parameter int NUM_W = 58,
  parameter int QUO_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ppcm_ctl_t        in_ctl,
  input  logic [NUM_W-1:0] in_num_x,
  input  logic [NUM_W-1:0] in_num_y,
  input  logic [NUM_W-1:0] in_den,
  output ppcm_ctl_t        out_ctl,
  output logic [QUO_W-1:0] out_quo_x,
  output logic [QUO_W-1:0] out_quo_y,
  output logic             out_ovf_x,
  output logic             out_ovf_y
);

  localparam int DW = NUM_W + QUO_W;
  localparam int NS = QUO_W + 1;

  ppcm_ctl_t        ctl_r [NS];
  logic [NUM_W-1:0] rx_r  [NS];
  logic [NUM_W-1:0] ry_r  [NS];
  logic [NUM_W-1:0] den_r [NS];
  logic [QUO_W-1:0] qx_r  [NS];
  logic [QUO_W-1:0] qy_r  [NS];
  logic             ovx_r [NS];
  logic             ovy_r [NS];

  logic [DW-1:0] den_top;
  assign den_top = {in_den, {QUO_W{1'b0}}};

  // first stage: quotient reaches 2^QUO_W or more
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= in_ctl;
    end
    rx_r[0]  <= in_num_x;
    ry_r[0]  <= in_num_y;
    den_r[0] <= in_den;
    qx_r[0]  <= '0;
    qy_r[0]  <= '0;
    ovx_r[0] <= {{QUO_W{1'b0}}, in_num_x} >= den_top;
    ovy_r[0] <= {{QUO_W{1'b0}}, in_num_y} >= den_top;
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k < NS; k++) begin : g_stage
    localparam int B = QUO_W - k;

    logic [DW-1:0]    sub;
    logic             ge_x;
    logic             ge_y;
    logic [NUM_W-1:0] rx_nxt;
    logic [NUM_W-1:0] ry_nxt;
    logic [QUO_W-1:0] qx_nxt;
    logic [QUO_W-1:0] qy_nxt;

    assign sub  = {{QUO_W{1'b0}}, den_r[k-1]} << B;
    assign ge_x = {{QUO_W{1'b0}}, rx_r[k-1]} >= sub;
    assign ge_y = {{QUO_W{1'b0}}, ry_r[k-1]} >= sub;

    always_comb begin
      rx_nxt    = ge_x ? (rx_r[k-1] - sub[NUM_W-1:0]) : rx_r[k-1];
      ry_nxt    = ge_y ? (ry_r[k-1] - sub[NUM_W-1:0]) : ry_r[k-1];
      qx_nxt    = qx_r[k-1];
      qy_nxt    = qy_r[k-1];
      qx_nxt[B] = ge_x;
      qy_nxt[B] = ge_y;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_r[k-1];
      end
      rx_r[k]  <= rx_nxt;
      ry_r[k]  <= ry_nxt;
      den_r[k] <= den_r[k-1];
      qx_r[k]  <= qx_nxt;
      qy_r[k]  <= qy_nxt;
      ovx_r[k] <= ovx_r[k-1];
      ovy_r[k] <= ovy_r[k-1];
    end
  end

  assign out_ctl   = ctl_r[NS-1];
  assign out_quo_x = qx_r[NS-1];
  assign out_quo_y = qy_r[NS-1];
  assign out_ovf_x = ovx_r[NS-1];
  assign out_ovf_y = ovy_r[NS-1];

endmodule

### rtl/core/projective_pixel_coordinate_map_top.sv
// top level of the projective pixel coordinate map: coefficient registers,
// multiply and sum stages, output clamp; uses ppcm_pkg, ppcm_div and the assert header
`include "projective_pixel_coordinate_map_top_assert.svh"

// Maps a pixel (row, col) through a homography with its last coefficient
// fixed at one: x = a*col + b*row + c, y = d*col + e*row + f,
// w = g*col + h*row + 1, all in signed Q23.24. The outputs are x/w and y/w
// truncated toward zero and clamped to 0..IMAGE_WIDTH-1 and 0..IMAGE_HEIGHT-1
// (then cut to 10 bits); a zero w gives degenerate = 1 and coordinates 0,0.
// A new item is taken in every cycle (busy stays low) and its result shows on
// out_strobe for one cycle. QUO_W is the bit count of the larger image side,
// at least 10. An item passes the multiply, sum and magnitude stages, then the
// divider's overflow check and one quotient bit per stage, then the clamp stage.
// The receiver cannot stall, so no result is ever held back. Coefficients are
// written over the APB-style port at byte address 8*i; the user must write them
// only while no item is in flight, which the block itself does not enforce.
module projective_pixel_coordinate_map_top import ppcm_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      in_pixel_row,
  input  logic [PIX_W-1:0]      in_pixel_col,
  // result channel
  output logic                  out_strobe,
  output logic [OUT_W-1:0]      out_mapped_row,
  output logic [OUT_W-1:0]      out_mapped_col,
  output logic                  out_degenerate,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // quotient bits needed to reach the larger image side
  localparam int MAX_SIDE = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int QB       = $clog2(MAX_SIDE);
  localparam int QUO_W    = (QB < OUT_W) ? OUT_W : QB;
  localparam int LATENCY  = QUO_W + 5;

  // product, sum and magnitude widths
  localparam int MUL_W  = COEF_W + PIX_W + 1;
  localparam int PROD_W = COEF_W + PIX_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NUM_W  = SUM_W - 1;

  localparam logic [QUO_W-1:0] COL_MAX = QUO_W'(IMAGE_WIDTH - 1);
  localparam logic [QUO_W-1:0] ROW_MAX = QUO_W'(IMAGE_HEIGHT - 1);

  // ---------------------------------------------------------------------------
  // coefficient registers
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0]    coef_r [NUM_REGS];
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_BYTE_SHIFT];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= coef_reset(REG_IDX_W'(i));
      end
    end else if (cfg_wr) begin
      coef_r[cfg_idx] <= pwdata[COEF_W-1:0];
    end
  end

  // read returns the stored 48-bit value, zero extended
  assign prdata = {{(CFG_DATA_W - COEF_W){1'b0}}, coef_r[cfg_idx]};

  logic signed [COEF_W-1:0] k_xc, k_xr, k_xo, k_yc, k_yr, k_yo, k_wc, k_wr;
  assign k_xc = coef_r[REG_X_COL];
  assign k_xr = coef_r[REG_X_ROW];
  assign k_xo = coef_r[REG_X_OFS];
  assign k_yc = coef_r[REG_Y_COL];
  assign k_yr = coef_r[REG_Y_ROW];
  assign k_yo = coef_r[REG_Y_OFS];
  assign k_wc = coef_r[REG_W_COL];
  assign k_wr = coef_r[REG_W_ROW];

  // the pipeline takes an item in every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // stage 1: six coefficient by pixel products
  // ---------------------------------------------------------------------------
  logic signed [PIX_W:0]  col_s, row_s;
  logic signed [MUL_W-1:0] m_xc, m_xr, m_yc, m_yr, m_wc, m_wr;

  assign col_s = $signed({1'b0, in_pixel_col});
  assign row_s = $signed({1'b0, in_pixel_row});
  assign m_xc  = k_xc * col_s;
  assign m_xr  = k_xr * row_s;
  assign m_yc  = k_yc * col_s;
  assign m_yr  = k_yr * row_s;
  assign m_wc  = k_wc * col_s;
  assign m_wr  = k_wr * row_s;

  logic                     s1_valid_r;
  logic signed [PROD_W-1:0] p_xc_r, p_xr_r, p_yc_r, p_yr_r, p_wc_r, p_wr_r;

  // products stay below 2^57 in magnitude, so the top bit of the full
  // product is only a copy of the sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    p_xc_r <= m_xc[PROD_W-1:0];
    p_xr_r <= m_xr[PROD_W-1:0];
    p_yc_r <= m_yc[PROD_W-1:0];
    p_yr_r <= m_yr[PROD_W-1:0];
    p_wc_r <= m_wc[PROD_W-1:0];
    p_wr_r <= m_wr[PROD_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // stage 2: x, y and w sums, exact
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] x_nxt, y_nxt, w_nxt;
  logic signed [SUM_W-1:0] x_r, y_r, w_r;
  logic                    s2_valid_r;

  always_comb begin
    x_nxt = SUM_W'(p_xc_r) + SUM_W'(p_xr_r) + SUM_W'(k_xo);
    y_nxt = SUM_W'(p_yc_r) + SUM_W'(p_yr_r) + SUM_W'(k_yo);
    w_nxt = SUM_W'(p_wc_r) + SUM_W'(p_wr_r) + $signed(SUM_W'(Q_ONE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    w_r <= w_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 3: magnitudes and quotient signs
  // ---------------------------------------------------------------------------
  logic             x_sgn, y_sgn, w_sgn;
  logic [SUM_W-1:0] x_mag, y_mag, w_mag;
  ppcm_ctl_t        s3_ctl_nxt, s3_ctl_r;
  logic [NUM_W-1:0] ax_r, ay_r, aw_r;

  assign x_sgn = x_r[SUM_W-1];
  assign y_sgn = y_r[SUM_W-1];
  assign w_sgn = w_r[SUM_W-1];

  always_comb begin
    x_mag = x_sgn ? -x_r : x_r;
    y_mag = y_sgn ? -y_r : y_r;
    w_mag = w_sgn ? -w_r : w_r;
    s3_ctl_nxt.valid  = s2_valid_r;
    s3_ctl_nxt.zero_w = (w_r == '0);
    // signs that differ mean a quotient at or below zero
    s3_ctl_nxt.neg_x  = x_sgn ^ w_sgn;
    s3_ctl_nxt.neg_y  = y_sgn ^ w_sgn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s3_ctl_nxt;
    end
    ax_r <= x_mag[NUM_W-1:0];
    ay_r <= y_mag[NUM_W-1:0];
    aw_r <= w_mag[NUM_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // stages 4 .. QUO_W+4: overflow check, then one quotient bit per stage
  // ---------------------------------------------------------------------------
  ppcm_ctl_t        div_ctl;
  logic [QUO_W-1:0] quo_x, quo_y;
  logic             ovf_x, ovf_y;

  ppcm_div #(
    .NUM_W (NUM_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (s3_ctl_r),
    .in_num_x  (ax_r),
    .in_num_y  (ay_r),
    .in_den    (aw_r),
    .out_ctl   (div_ctl),
    .out_quo_x (quo_x),
    .out_quo_y (quo_y),
    .out_ovf_x (ovf_x),
    .out_ovf_y (ovf_y)
  );

  // ---------------------------------------------------------------------------
  // last stage: clamp into the image and register the result
  // ---------------------------------------------------------------------------
  logic [QUO_W-1:0] row_c, col_c;
  logic             out_strobe_r, out_degen_r;
  logic [OUT_W-1:0] out_row_r, out_col_r;

  always_comb begin
    priority if (div_ctl.zero_w || div_ctl.neg_y) begin
      row_c = '0;
    end else if (ovf_y || quo_y > ROW_MAX) begin
      row_c = ROW_MAX;
    end else begin
      row_c = quo_y;
    end
    priority if (div_ctl.zero_w || div_ctl.neg_x) begin
      col_c = '0;
    end else if (ovf_x || quo_x > COL_MAX) begin
      col_c = COL_MAX;
    end else begin
      col_c = quo_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_ctl.valid;
    end
    out_row_r   <= row_c[OUT_W-1:0];
    out_col_r   <= col_c[OUT_W-1:0];
    out_degen_r <= div_ctl.zero_w;
  end

  assign out_strobe     = out_strobe_r;
  assign out_mapped_row = out_row_r;
  assign out_mapped_col = out_col_r;
  assign out_degenerate = out_degen_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // every accepted item gives its result on out_strobe
  `PPCM_ASSERT_IMP(a_item_result, start && !busy, ##LATENCY out_strobe)
  // no result on out_strobe without an accepted item before it
  `PPCM_ASSERT_IMP(a_no_stray_result, out_strobe, $past(start && !busy, LATENCY))
  // a degenerate result carries coordinates 0,0
  `PPCM_ASSERT_IMP(a_degen_zero, out_strobe && out_degenerate,
                   out_mapped_row == '0 && out_mapped_col == '0)
  // a write lands in the addressed coefficient
  `PPCM_ASSERT_NXT(a_cfg_write, cfg_wr,
                   coef_r[$past(cfg_idx)] == $past(pwdata[COEF_W-1:0]))

endmodule
